### src/tsup_pkg.sv
`default_nettype none

package tsup_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int ALPHABET   = 26;

    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int FREE_W   = NODE_W + 1;
    localparam int COL_W    = $clog2(ALPHABET);
    localparam int LETTER_W = 5;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_POOL_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NO_PATH   = 2'd2;

    localparam logic [CNT_W-1:0] CNT_ONE = 2'd1;
    localparam logic [CNT_W-1:0] CNT_MAX = 2'd2;

    // One child slot: the child node and that child's pass count. Every node
    // but the root has exactly one parent slot, so its count lives there.
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [NODE_W-1:0] child;
    } link_t;

    typedef link_t [ALPHABET-1:0] link_row_t;

endpackage

`default_nettype wire

### src/trie_shortest_unique_prefix_unit.sv
`default_nettype none

// Channel   Handshake                 Payload
// -------   -----------------------   -------------------------------------
// request   in_valid / in_stall       op, letter, word_end
// result    out_valid / out_stall     emit, out_letter, prefix_end, status
//
// A request is handled by a read and then a lookup: on accept the current node's
// row of child slots is read from the link memory; in the lookup state the
// letter's slot is selected and written back and the result register is loaded.
// The single read-modify-write memory port sets this split; a stalled result
// register holds the lookup. Reset and the clear op run a clearing pass over all
// NODE_COUNT (1024) rows, one row a cycle, during which in_stall stays high.
// A new request is taken while a finished result still waits in the
// result register.

module trie_shortest_unique_prefix_unit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [tsup_pkg::OP_W-1:0]     op,
    input  wire logic [tsup_pkg::LETTER_W-1:0] letter,
    input  wire logic                          word_end,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               emit,
    output logic [tsup_pkg::LETTER_W-1:0]      out_letter,
    output logic                               prefix_end,
    output logic [tsup_pkg::STATUS_W-1:0]      status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_CLEAR
    } state_t;

    // Link memory: one row per node, one slot per letter. Row-wide read,
    // slot-wide write, row-wide clear.
    tsup_pkg::link_row_t link_mem [tsup_pkg::NODE_COUNT];
    tsup_pkg::link_row_t rd_row_reg;

    state_t                              state_reg, state_next;
    logic [tsup_pkg::NODE_W-1:0]         walk_node_reg, walk_node_next;
    logic [tsup_pkg::FREE_W-1:0]         next_free_reg, next_free_next;
    logic                                prefix_done_reg, prefix_done_next;
    logic                                word_failed_reg, word_failed_next;
    logic [tsup_pkg::NODE_W-1:0]         clr_idx_reg, clr_idx_next;

    // Request held for the lookup cycle
    logic [tsup_pkg::OP_W-1:0]           op_reg;
    logic [tsup_pkg::LETTER_W-1:0]       letter_reg;
    logic                                word_end_reg;

    logic                                out_valid_reg, out_valid_next;
    logic                                emit_reg, emit_next;
    logic [tsup_pkg::LETTER_W-1:0]       out_letter_reg, out_letter_next;
    logic                                prefix_end_reg, prefix_end_next;
    logic [tsup_pkg::STATUS_W-1:0]       status_reg, status_next;

    logic                                accept;
    logic                                slot_free;
    logic                                active;
    logic                                bad_letter;
    logic [tsup_pkg::COL_W-1:0]          col;
    tsup_pkg::link_t                     link;
    tsup_pkg::link_t                     wr_link;
    logic                                wr_en;
    logic                                clr_we;

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign slot_free  = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign emit       = emit_reg;
    assign out_letter = out_letter_reg;
    assign prefix_end = prefix_end_reg;
    assign status     = status_reg;

    assign col        = tsup_pkg::COL_W'(letter_reg);
    assign bad_letter = (letter_reg >= tsup_pkg::LETTER_W'(tsup_pkg::ALPHABET));
    assign link       = rd_row_reg[col];
    assign clr_we     = (state_reg == S_CLEAR);

    // Insert and query letters only act until the word fails; a query also
    // stops once its prefix has been reported.
    assign active = ((op_reg == tsup_pkg::OP_INSERT) || (op_reg == tsup_pkg::OP_QUERY))
                    && !word_failed_reg
                    && !((op_reg == tsup_pkg::OP_QUERY) && prefix_done_reg);

    always_comb
    begin
        state_next       = state_reg;
        walk_node_next   = walk_node_reg;
        next_free_next   = next_free_reg;
        prefix_done_next = prefix_done_reg;
        word_failed_next = word_failed_reg;
        clr_idx_next     = clr_idx_reg;
        out_valid_next   = out_valid_reg && out_stall;
        emit_next        = emit_reg;
        out_letter_next  = out_letter_reg;
        prefix_end_next  = prefix_end_reg;
        status_next      = status_reg;
        wr_en            = 1'b0;
        wr_link          = link;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOKUP;
                end
            end

            S_LOOKUP:
            begin
                // Hold the lookup while the result register is still full and stalled.
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    emit_next       = 1'b0;
                    out_letter_next = '0;
                    prefix_end_next = 1'b0;
                    status_next     = tsup_pkg::STS_OK;
                    state_next      = S_IDLE;

                    if (op_reg == tsup_pkg::OP_CLEAR)
                    begin
                        walk_node_next   = '0;
                        next_free_next   = tsup_pkg::FREE_W'(1);
                        prefix_done_next = 1'b0;
                        word_failed_next = 1'b0;
                        clr_idx_next     = '0;
                        state_next       = S_CLEAR;
                    end
                    else if ((op_reg == tsup_pkg::OP_INSERT) || (op_reg == tsup_pkg::OP_QUERY))
                    begin
                        if (active)
                        begin
                            if (bad_letter)
                            begin
                                status_next      = tsup_pkg::STS_NO_PATH;
                                word_failed_next = 1'b1;
                            end
                            else if (op_reg == tsup_pkg::OP_INSERT)
                            begin
                                if (link.child == '0)
                                begin
                                    if (next_free_reg >= tsup_pkg::FREE_W'(tsup_pkg::NODE_COUNT))
                                    begin
                                        status_next      = tsup_pkg::STS_POOL_FULL;
                                        word_failed_next = 1'b1;
                                    end
                                    else
                                    begin
                                        // Allocate: a fresh node has been passed once.
                                        wr_link.child  = next_free_reg[tsup_pkg::NODE_W-1:0];
                                        wr_link.cnt    = tsup_pkg::CNT_ONE;
                                        wr_en          = 1'b1;
                                        walk_node_next = next_free_reg[tsup_pkg::NODE_W-1:0];
                                        next_free_next = next_free_reg + tsup_pkg::FREE_W'(1);
                                    end
                                end
                                else
                                begin
                                    wr_link.cnt    = (link.cnt == tsup_pkg::CNT_MAX) ?
                                                     tsup_pkg::CNT_MAX :
                                                     link.cnt + tsup_pkg::CNT_W'(1);
                                    wr_en          = 1'b1;
                                    walk_node_next = link.child;
                                end
                            end
                            else
                            begin
                                if (link.child == '0)
                                begin
                                    status_next      = tsup_pkg::STS_NO_PATH;
                                    word_failed_next = 1'b1;
                                end
                                else
                                begin
                                    walk_node_next  = link.child;
                                    emit_next       = 1'b1;
                                    out_letter_next = letter_reg;
                                    if ((link.cnt == tsup_pkg::CNT_ONE) || word_end_reg)
                                    begin
                                        prefix_end_next  = 1'b1;
                                        prefix_done_next = 1'b1;
                                    end
                                end
                            end
                        end

                        // Word end: walk returns to the root.
                        if (word_end_reg)
                        begin
                            walk_node_next   = '0;
                            prefix_done_next = 1'b0;
                            word_failed_next = 1'b0;
                        end
                    end
                end
            end

            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + tsup_pkg::NODE_W'(1);
                if (clr_idx_reg == tsup_pkg::NODE_W'(tsup_pkg::NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            walk_node_reg   <= '0;
            next_free_reg   <= tsup_pkg::FREE_W'(1);
            prefix_done_reg <= 1'b0;
            word_failed_reg <= 1'b0;
            clr_idx_reg     <= '0;
            op_reg          <= '0;
            letter_reg      <= '0;
            word_end_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            emit_reg        <= 1'b0;
            out_letter_reg  <= '0;
            prefix_end_reg  <= 1'b0;
            status_reg      <= tsup_pkg::STS_OK;
        end
        else
        begin
            state_reg       <= state_next;
            walk_node_reg   <= walk_node_next;
            next_free_reg   <= next_free_next;
            prefix_done_reg <= prefix_done_next;
            word_failed_reg <= word_failed_next;
            clr_idx_reg     <= clr_idx_next;
            if (accept)
            begin
                op_reg       <= op;
                letter_reg   <= letter;
                word_end_reg <= word_end;
            end
            out_valid_reg   <= out_valid_next;
            emit_reg        <= emit_next;
            out_letter_reg  <= out_letter_next;
            prefix_end_reg  <= prefix_end_next;
            status_reg      <= status_next;
        end
    end

    // Read the current node's row on accept; write back in the lookup cycle.
    // A read never shares a cycle with a write, and the write lands before
    // the next request can be accepted, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (clr_we)
        begin
            link_mem[clr_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            link_mem[walk_node_reg][col] <= wr_link;
        end

        if (accept)
        begin
            rd_row_reg <= link_mem[walk_node_reg];
        end
    end

endmodule

`default_nettype wire

### src/tsup_checker.sv
`default_nettype none

module tsup_checker
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic                          emit,
    input  wire logic [tsup_pkg::LETTER_W-1:0] out_letter,
    input  wire logic                          prefix_end,
    input  wire logic [tsup_pkg::STATUS_W-1:0] status
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(emit) && $stable(out_letter)
                                   && $stable(prefix_end) && $stable(status))
        else $error("stalled result changed");

    // Each request occupies the lookup cycle after it is taken.
    a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted on back-to-back cycles");

    // An echoed letter always comes with a good status.
    a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && emit |-> status == tsup_pkg::STS_OK)
        else $error("emit with error status");

    // Suppressed letters carry no letter and no prefix end.
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !emit |-> out_letter == '0 && !prefix_end)
        else $error("non-emitted result carries letter data");

endmodule

bind trie_shortest_unique_prefix_unit tsup_checker u_tsup_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .emit       (emit),
    .out_letter (out_letter),
    .prefix_end (prefix_end),
    .status     (status)
);

`default_nettype wire
